// ===== rtl/twh_pkg.sv =====
// shared types, constants and helpers of the temperature binned weighted histogram
package twh_pkg;

    // register map (word index)
    localparam logic [1:0] REG_TEMP_LOW    = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
    localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

    localparam logic [15:0] TEMP_LOW_RST    = 16'd6554;
    localparam logic [15:0] BIN_WIDTH_RST   = 16'd66;
    localparam logic [9:0]  BINS_IN_USE_RST = 10'd400;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BELOW  = 2'd1;
    localparam logic [1:0] STATUS_BEYOND = 2'd2;

    // iteration counts of the sequential units
    localparam int DIV_STEPS   = 16;
    localparam int GDIV_STEPS  = 64;
    localparam int SQRT_STEPS  = 32;
    localparam int RATIO_STEPS = 16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] temperature;
        logic [31:0] cell_volume;
        logic [15:0] speed;
        logic [31:0] energy_density;
        logic [8:0]  bin_select;
    } sample_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  bin_number;
        logic [15:0] bin_center;
        logic [63:0] bin_volume;
        logic [15:0] mean_speed;
    } result_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_BIN,
        S_VOL_RD,
        S_VOL_ADD,
        S_GDIV,
        S_GPREP,
        S_SQRT,
        S_M_VG,
        S_M_LO,
        S_M_HI,
        S_W_SUM,
        S_F_LO,
        S_F_HI,
        S_F_SUM,
        S_EF_ADD,
        S_RD_CHK,
        S_RD_WAIT,
        S_RD_DATA,
        S_RATIO,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic set_bin;
        logic set_sel;
        logic vol_wr;
        logic gdiv_step;
        logic sqrt_init;
        logic sqrt_step;
        logic mul_vg;
        logic mul_lo;
        logic mul_hi;
        logic w_sum;
        logic f_lo;
        logic f_hi;
        logic f_sum;
        logic ef_wr;
        logic rd_latch;
        logic ratio_step;
        logic out_load;
        logic clear_wr;
    } cmd_t;

    typedef struct packed {
        logic in_read;
        logic op_flow;
        logic dropped;
        logic sel_bad;
        logic out_free;
    } sts_t;

    function automatic logic [63:0] sat_val(input logic [63:0] x, input logic [63:0] maxv);
        sat_val = (x > maxv) ? maxv : x;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] maxv);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = (s > {1'b0, maxv}) ? maxv : s[63:0];
    endfunction

endpackage

// ===== rtl/twh_ram.sv =====
// generic single write port ram with registered read
module twh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/twh_ctrl.sv =====
// sequencer for the histogram: clearing pass, per operation step sequence
module twh_ctrl #(
    parameter int NUM_BINS = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  twh_pkg::sts_t               sts,
    output twh_pkg::cmd_t               cmd,
    output logic [$clog2(NUM_BINS)-1:0] clear_addr
);

    localparam int AW = $clog2(NUM_BINS);
    localparam int CW = (AW > 7) ? AW : 7;

    twh_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twh_pkg::S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign clear_addr   = cnt_reg[AW-1:0];
    assign sample_stall = (state_reg != twh_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            twh_pkg::S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (cnt_reg == CW'(NUM_BINS - 1))
                begin
                    cnt_next   = '0;
                    state_next = twh_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            twh_pkg::S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = sts.in_read ? twh_pkg::S_RD_CHK : twh_pkg::S_DIV;
                end
            end
            twh_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(twh_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = twh_pkg::S_BIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            twh_pkg::S_BIN:
            begin
                cmd.set_bin = 1'b1;
                if (sts.dropped)
                begin
                    state_next = twh_pkg::S_FINISH;
                end
                else if (sts.op_flow)
                begin
                    state_next = twh_pkg::S_GDIV;
                end
                else
                begin
                    state_next = twh_pkg::S_VOL_RD;
                end
            end
            twh_pkg::S_VOL_RD:
            begin
                state_next = twh_pkg::S_VOL_ADD;
            end
            twh_pkg::S_VOL_ADD:
            begin
                cmd.vol_wr = 1'b1;
                state_next = twh_pkg::S_FINISH;
            end
            twh_pkg::S_GDIV:
            begin
                cmd.gdiv_step = 1'b1;
                if (cnt_reg == CW'(twh_pkg::GDIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = twh_pkg::S_GPREP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            twh_pkg::S_GPREP:
            begin
                cmd.sqrt_init = 1'b1;
                state_next    = twh_pkg::S_SQRT;
            end
            twh_pkg::S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CW'(twh_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = twh_pkg::S_M_VG;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            twh_pkg::S_M_VG:
            begin
                cmd.mul_vg = 1'b1;
                state_next = twh_pkg::S_M_LO;
            end
            twh_pkg::S_M_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = twh_pkg::S_M_HI;
            end
            twh_pkg::S_M_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = twh_pkg::S_W_SUM;
            end
            twh_pkg::S_W_SUM:
            begin
                cmd.w_sum  = 1'b1;
                state_next = twh_pkg::S_F_LO;
            end
            twh_pkg::S_F_LO:
            begin
                cmd.f_lo   = 1'b1;
                state_next = twh_pkg::S_F_HI;
            end
            twh_pkg::S_F_HI:
            begin
                cmd.f_hi   = 1'b1;
                state_next = twh_pkg::S_F_SUM;
            end
            twh_pkg::S_F_SUM:
            begin
                cmd.f_sum  = 1'b1;
                state_next = twh_pkg::S_EF_ADD;
            end
            twh_pkg::S_EF_ADD:
            begin
                cmd.ef_wr  = 1'b1;
                state_next = twh_pkg::S_FINISH;
            end
            twh_pkg::S_RD_CHK:
            begin
                cmd.set_sel = 1'b1;
                state_next  = sts.sel_bad ? twh_pkg::S_FINISH : twh_pkg::S_RD_WAIT;
            end
            twh_pkg::S_RD_WAIT:
            begin
                state_next = twh_pkg::S_RD_DATA;
            end
            twh_pkg::S_RD_DATA:
            begin
                cmd.rd_latch = 1'b1;
                cnt_next     = '0;
                state_next   = twh_pkg::S_RATIO;
            end
            twh_pkg::S_RATIO:
            begin
                cmd.ratio_step = 1'b1;
                if (cnt_reg == CW'(twh_pkg::RATIO_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = twh_pkg::S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            twh_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = twh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = twh_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/twh_dp.sv =====
// histogram datapath: binning divider, gamma units, shared multiplier, bin stores, result register
module twh_dp #(
    parameter int NUM_BINS = 512,
    parameter int SUM_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  twh_pkg::cmd_t               cmd,
    input  logic [$clog2(NUM_BINS)-1:0] clear_addr,
    output twh_pkg::sts_t               sts,
    input  logic [15:0]                 temp_low,
    input  logic [15:0]                 bin_width,
    input  logic [9:0]                  bins_in_use,
    input  twh_pkg::sample_t            sample,
    input  logic                        result_stall,
    output twh_pkg::result_t            result,
    output logic                        result_valid
);

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SUM_BITS);

    twh_pkg::sample_t smp_reg;
    logic             below_reg;
    logic [16:0]      rem_reg;
    logic [15:0]      quot_reg;
    logic [32:0]      gd_reg;
    logic [32:0]      gr_reg;
    logic [63:0]      gq_reg;
    logic [63:0]      sn_reg, sr_reg, sb_reg;
    logic [63:0]      mul_reg, lo_reg;
    logic [31:0]      hi_reg;
    logic [63:0]      w_reg, f_reg;
    logic [AW-1:0]    addr_reg;
    logic [1:0]       status_reg;
    logic [8:0]       bin_num_reg;
    logic             read_ok_reg;
    logic [15:0]      center_reg;
    logic [63:0]      vol_out_reg;
    logic             ezero_reg, fge_reg;
    logic [63:0]      rr_reg, den_reg;
    logic [15:0]      rq_reg;
    twh_pkg::result_t result_reg;
    logic             result_valid_reg;

    logic [15:0]      bw;
    logic [16:0]      nb;
    logic [16:0]      div_sh;
    logic [33:0]      g_sh;
    logic [63:0]      sq_try;
    logic [31:0]      gamma;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      prod;
    logic [95:0]      acc;
    logic [64:0]      r_sh;
    logic [25:0]      center_sum;
    logic [31:0]      spd_sq;
    logic [15:0]      mean;
    logic             ram_we_vol, ram_we_ef;
    logic [AW-1:0]    waddr;
    logic [SUM_BITS-1:0] vol_wdata, e_wdata, f_wdata;
    logic [SUM_BITS-1:0] vol_rd, e_rd, f_rd;

    assign bw     = (bin_width == 16'd0) ? 16'd1 : bin_width;
    assign nb     = (17'(bins_in_use) < 17'(NUM_BINS)) ? 17'(bins_in_use) : 17'(NUM_BINS);
    assign div_sh = {rem_reg[15:0], quot_reg[15]};
    assign g_sh   = {gr_reg, 1'b0};
    assign sq_try = sr_reg + sb_reg;
    assign gamma  = (sr_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : sr_reg[31:0];
    assign r_sh   = {rr_reg, 1'b0};
    assign spd_sq = 32'(sample.speed) * 32'(sample.speed);
    assign center_sum = 26'(temp_low) + 26'(smp_reg.bin_select) * 26'(bw) + 26'(bw >> 1);
    assign mean   = ezero_reg ? 16'd0 : (fge_reg ? 16'hFFFF : rq_reg);

    // one shared 32x32 multiplier
    always_comb
    begin
        mul_a = mul_reg[31:0];
        mul_b = smp_reg.energy_density;
        if (cmd.mul_vg)
        begin
            mul_a = smp_reg.cell_volume;
            mul_b = gamma;
        end
        else if (cmd.mul_hi)
        begin
            mul_a = hi_reg;
        end
        else if (cmd.f_lo)
        begin
            mul_a = w_reg[31:0];
            mul_b = 32'(smp_reg.speed);
        end
        else if (cmd.f_hi)
        begin
            mul_a = w_reg[63:32];
            mul_b = 32'(smp_reg.speed);
        end
    end

    assign prod = mul_a * mul_b;
    assign acc  = {32'd0, lo_reg} + {mul_reg, 32'd0};

    assign sts.in_read  = sample.operation[1];
    assign sts.op_flow  = smp_reg.operation[0];
    assign sts.dropped  = below_reg || ({1'b0, quot_reg} >= nb);
    assign sts.sel_bad  = (17'(smp_reg.bin_select) >= nb);
    assign sts.out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg   <= sample;
            below_reg <= (sample.temperature < temp_low);
            rem_reg   <= '0;
            quot_reg  <= sample.temperature - temp_low;
            gd_reg    <= 33'h1_0000_0000 - 33'(spd_sq);
            gr_reg    <= 33'd1;
            gq_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            if (div_sh >= {1'b0, bw})
            begin
                rem_reg  <= div_sh - {1'b0, bw};
                quot_reg <= {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg  <= div_sh;
                quot_reg <= {quot_reg[14:0], 1'b0};
            end
        end
        if (cmd.set_bin)
        begin
            addr_reg    <= AW'(quot_reg);
            read_ok_reg <= 1'b0;
            bin_num_reg <= sts.dropped ? 9'd0 : quot_reg[8:0];
            status_reg  <= below_reg ? twh_pkg::STATUS_BELOW
                         : (sts.dropped ? twh_pkg::STATUS_BEYOND : twh_pkg::STATUS_OK);
        end
        if (cmd.set_sel)
        begin
            addr_reg    <= AW'(smp_reg.bin_select);
            read_ok_reg <= !sts.sel_bad;
            bin_num_reg <= smp_reg.bin_select;
            status_reg  <= sts.sel_bad ? twh_pkg::STATUS_BEYOND : twh_pkg::STATUS_OK;
            center_reg  <= (center_sum > 26'h00_FFFF) ? 16'hFFFF : center_sum[15:0];
        end
        // 2^64 / (1 - v^2), one quotient bit per cycle
        if (cmd.gdiv_step)
        begin
            if (g_sh >= {1'b0, gd_reg})
            begin
                gr_reg <= 33'(g_sh - {1'b0, gd_reg});
                gq_reg <= {gq_reg[62:0], 1'b1};
            end
            else
            begin
                gr_reg <= g_sh[32:0];
                gq_reg <= {gq_reg[62:0], 1'b0};
            end
        end
        if (cmd.sqrt_init)
        begin
            sn_reg <= gq_reg;
            sr_reg <= '0;
            sb_reg <= 64'h4000_0000_0000_0000;
        end
        // integer square root, two radicand bits per cycle
        if (cmd.sqrt_step)
        begin
            if (sn_reg >= sq_try)
            begin
                sn_reg <= sn_reg - sq_try;
                sr_reg <= (sr_reg >> 1) + sb_reg;
            end
            else
            begin
                sr_reg <= sr_reg >> 1;
            end
            sb_reg <= sb_reg >> 2;
        end
        if (cmd.mul_vg || cmd.mul_lo || cmd.mul_hi || cmd.f_lo || cmd.f_hi)
        begin
            mul_reg <= prod;
        end
        if (cmd.mul_lo)
        begin
            hi_reg <= mul_reg[63:32];
        end
        if (cmd.mul_hi || cmd.f_hi)
        begin
            lo_reg <= mul_reg;
        end
        if (cmd.w_sum)
        begin
            w_reg <= twh_pkg::sat_val(64'(acc[95:48]), SUM_MAX);
        end
        if (cmd.f_sum)
        begin
            f_reg <= (acc[95:80] != 16'd0) ? SUM_MAX : twh_pkg::sat_val(acc[79:16], SUM_MAX);
        end
        if (cmd.rd_latch)
        begin
            vol_out_reg <= 64'(vol_rd);
            ezero_reg   <= (e_rd == '0);
            fge_reg     <= (f_rd >= e_rd);
            rr_reg      <= 64'(f_rd);
            den_reg     <= 64'(e_rd);
            rq_reg      <= '0;
        end
        if (cmd.ratio_step)
        begin
            if (r_sh >= {1'b0, den_reg})
            begin
                rr_reg <= 64'(r_sh - {1'b0, den_reg});
                rq_reg <= {rq_reg[14:0], 1'b1};
            end
            else
            begin
                rr_reg <= r_sh[63:0];
                rq_reg <= {rq_reg[14:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            result_reg.status     <= status_reg;
            result_reg.bin_number <= bin_num_reg;
            result_reg.bin_center <= read_ok_reg ? center_reg : 16'd0;
            result_reg.bin_volume <= read_ok_reg ? vol_out_reg : 64'd0;
            result_reg.mean_speed <= read_ok_reg ? mean : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // bin stores
    assign ram_we_vol = cmd.clear_wr || cmd.vol_wr;
    assign ram_we_ef  = cmd.clear_wr || cmd.ef_wr;
    assign waddr      = cmd.clear_wr ? clear_addr : addr_reg;
    assign vol_wdata  = cmd.clear_wr ? '0
                      : SUM_BITS'(twh_pkg::sat_add(64'(vol_rd), 64'(smp_reg.cell_volume), SUM_MAX));
    assign e_wdata    = cmd.clear_wr ? '0
                      : SUM_BITS'(twh_pkg::sat_add(64'(e_rd), w_reg, SUM_MAX));
    assign f_wdata    = cmd.clear_wr ? '0
                      : SUM_BITS'(twh_pkg::sat_add(64'(f_rd), f_reg, SUM_MAX));

    twh_ram #(.WIDTH(SUM_BITS), .DEPTH(NUM_BINS)) u_vol_ram (
        .clk   (clk),
        .we    (ram_we_vol),
        .waddr (waddr),
        .wdata (vol_wdata),
        .raddr (addr_reg),
        .rdata (vol_rd)
    );

    twh_ram #(.WIDTH(SUM_BITS), .DEPTH(NUM_BINS)) u_energy_ram (
        .clk   (clk),
        .we    (ram_we_ef),
        .waddr (waddr),
        .wdata (e_wdata),
        .raddr (addr_reg),
        .rdata (e_rd)
    );

    twh_ram #(.WIDTH(SUM_BITS), .DEPTH(NUM_BINS)) u_flow_ram (
        .clk   (clk),
        .we    (ram_we_ef),
        .waddr (waddr),
        .wdata (f_wdata),
        .raddr (addr_reg),
        .rdata (f_rd)
    );

endmodule

// ===== rtl/temperature_binned_weighted_histogram.sv =====
// top level of the temperature binned weighted histogram
//
//  channel   dir  handshake                    payload
//  sample    in   sample_valid / sample_stall  twh_pkg::sample_t
//  result    out  result_valid / result_stall  twh_pkg::result_t
//  config    in   apb psel/penable/pwrite      paddr[3:0], pwdata/prdata 32 bit
//
//  volume add: bin divider, then read-modify-write of the volume store
//  flow add: bin divider, gamma divider, square root, multiplies, then energy and flow store update
//  bin read: bin check, store read, then the mean ratio divider
//  after reset a clearing pass zeroes every bin of the stores, sample_stall high
//  a finished result waits in the output register while the next sample is taken
module temperature_binned_weighted_histogram #(
    parameter int NUM_BINS = 512,
    parameter int SUM_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    // sample channel
    input  logic              sample_valid,
    output logic              sample_stall,
    input  twh_pkg::sample_t  sample,
    // result channel
    output logic              result_valid,
    input  logic              result_stall,
    output twh_pkg::result_t  result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] temp_low_reg;
    logic [15:0] bin_width_reg;
    logic [9:0]  bins_in_use_reg;
    logic        cfg_wr;

    twh_pkg::cmd_t cmd;
    twh_pkg::sts_t sts;
    logic [$clog2(NUM_BINS)-1:0] clear_addr;

    // register access, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg    <= twh_pkg::TEMP_LOW_RST;
            bin_width_reg   <= twh_pkg::BIN_WIDTH_RST;
            bins_in_use_reg <= twh_pkg::BINS_IN_USE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                twh_pkg::REG_TEMP_LOW:    temp_low_reg    <= pwdata[15:0];
                twh_pkg::REG_BIN_WIDTH:   bin_width_reg   <= pwdata[15:0];
                twh_pkg::REG_BINS_IN_USE: bins_in_use_reg <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            twh_pkg::REG_TEMP_LOW:    prdata = 32'(temp_low_reg);
            twh_pkg::REG_BIN_WIDTH:   prdata = 32'(bin_width_reg);
            twh_pkg::REG_BINS_IN_USE: prdata = 32'(bins_in_use_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    // sequencer: clearing pass, then one sample at a time
    twh_ctrl #(.NUM_BINS(NUM_BINS)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sts          (sts),
        .cmd          (cmd),
        .clear_addr   (clear_addr)
    );

    // arithmetic, bin stores and output register
    twh_dp #(.NUM_BINS(NUM_BINS), .SUM_BITS(SUM_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .clear_addr   (clear_addr),
        .sts          (sts),
        .temp_low     (temp_low_reg),
        .bin_width    (bin_width_reg),
        .bins_in_use  (bins_in_use_reg),
        .sample       (sample),
        .result_stall (result_stall),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTHESIS
    // a taken sample keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample taken while previous one in progress");

    // a new result appears only from a sample in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result without sample in progress");
`endif

endmodule
